FILE: sv/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg: shared types for the binary min-heap queue
// Request, response and heap entry layouts, plus operation and status codes.
// ----------------------------------------------------------------------------
package hmq_pkg;

   localparam int KEY_W = 32;
   localparam int TAG_W = 16;
   localparam int OCC_W = 7;

   // Operation carried by a request transaction
   typedef enum logic [0:0] {
      FUNC_INSERT = 1'b0,
      FUNC_POP    = 1'b1
   } func_type;

   // Outcome reported with each response transaction
   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_POPPED    = 2'd1,
      ST_POP_EMPTY = 2'd2,
      ST_DROP_FULL = 2'd3
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [KEY_W-1:0]   key;
      logic [TAG_W-1:0]   tag;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]   out_key;
      logic [TAG_W-1:0]   out_tag;
      status_type         status;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   // One slot of heap storage
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [TAG_W-1:0]   tag;
   } entry_type;

endpackage

FILE: sv/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top: binary min-heap priority queue
// Sequencer, heap storage and response register.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH (key, tag) entries in a binary min-heap and
// handles one transaction at a time. An insert makes one comparison with a
// parent per level that it climbs (at most log2(DEPTH) comparisons); a pop
// loads the root and the last entry, then passes through S_PICK and S_SWAP
// at each level at which the children of the moving entry are compared (at
// most log2(DEPTH)-1 levels), because the single key comparator is used once
// to pick the smaller child and once to decide the swap, and each level needs
// a fresh registered read from the heap memory. A finished response sits in
// an output register, so the next request is taken while the previous
// response waits. An insert into a full heap is dropped and a pop of an empty
// heap is reported; neither changes the heap.
module binary_min_heap_queue_top
   import hmq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_payload,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   localparam int AW = $clog2(DEPTH);

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;
   logic [AW-1:0]    rd_addr0;
   logic [AW-1:0]    rd_addr1;
   entry_type        rd_data0;
   entry_type        rd_data1;
   logic             res_valid;
   logic             res_ready;
   rsp_type          res;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff,  rsp_data_in;

   hmq_seq #(.DEPTH(DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr0    (rd_addr0),
      .rd_addr1    (rd_addr1),
      .rd_data0    (rd_data0),
      .rd_data1    (rd_data1)
   );

   hmq_ram #(.DEPTH(DEPTH)) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // Load the response register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: sv/hmq_ram.sv
// ----------------------------------------------------------------------------
// hmq_ram: heap entry storage
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module hmq_ram
   import hmq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  entry_type                  wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr0,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr1,
   output entry_type                  rd_data0,
   output entry_type                  rd_data1
);

   entry_type mem [DEPTH];

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register both read ports
   always_ff @(posedge clock) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

FILE: sv/hmq_seq.sv
// ----------------------------------------------------------------------------
// hmq_seq: heap sequencer with shared key comparator
// Walks sift-up on insert and sift-down on pop, one comparison per cycle,
// keeping the moving entry in a register and filling the hole behind it.
// ----------------------------------------------------------------------------
module hmq_seq
   import hmq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_payload,
   output logic                       res_valid,
   input  logic                       res_ready,
   output rsp_type                    res,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output entry_type                  wr_data,
   output logic [$clog2(DEPTH)-1:0]   rd_addr0,
   output logic [$clog2(DEPTH)-1:0]   rd_addr1,
   input  entry_type                  rd_data0,
   input  entry_type                  rd_data1
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = AW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_LOAD,
      S_PICK,
      S_SWAP,
      S_DONE
   } state_type;

   state_type          state_ff,   state_in;
   logic [CW-1:0]      count_ff,   count_in;
   logic [AW-1:0]      pos_ff,     pos_in;
   entry_type          cur_ff,     cur_in;
   entry_type          pick_ff,    pick_in;
   logic [AW-1:0]      pidx_ff,    pidx_in;
   logic [KEY_W-1:0]   okey_ff,    okey_in;
   logic [TAG_W-1:0]   otag_ff,    otag_in;
   status_type         status_ff,  status_in;
   logic               wfin_ff,    wfin_in;

   logic [KEY_W-1:0]   cmp_a;
   logic [KEY_W-1:0]   cmp_b;
   logic               cmp_lt;
   logic [IW-1:0]      count_w;
   logic [IW-1:0]      lc_w;
   logic [IW-1:0]      rc_w;
   logic [IW-1:0]      nlc_w;
   logic [AW-1:0]      parent;

   // Shared key comparator
   assign cmp_lt  = cmp_a < cmp_b;

   assign count_w = IW'(count_ff);
   assign lc_w    = {pos_ff, 1'b1};
   assign rc_w    = lc_w + 1'b1;
   assign nlc_w   = {pidx_ff, 1'b1};
   assign parent  = (pos_ff - 1'b1) >> 1;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = '{out_key:   okey_ff,
                        out_tag:   otag_ff,
                        status:    status_ff,
                        occupancy: OCC_W'(count_ff)};

   // Sequence one transaction through the heap
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      pick_in   = pick_ff;
      pidx_in   = pidx_ff;
      okey_in   = okey_ff;
      otag_in   = otag_ff;
      status_in = status_ff;
      wfin_in   = wfin_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_addr0  = '0;
      rd_addr1  = '0;
      cmp_a     = '0;
      cmp_b     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               okey_in = '0;
               otag_in = '0;
               if (req_payload.func == FUNC_INSERT) begin
                  if (count_w == IW'(DEPTH)) begin
                     status_in = ST_DROP_FULL;
                     wfin_in   = 1'b0;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_INSERTED;
                     cur_in    = '{key: req_payload.key, tag: req_payload.tag};
                     pos_in    = AW'(count_ff);
                     count_in  = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        wfin_in  = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        rd_addr0 = AW'((count_ff - 1'b1) >> 1);
                        state_in = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_POP_EMPTY;
                     wfin_in   = 1'b0;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_POPPED;
                     rd_addr0  = '0;
                     rd_addr1  = AW'(count_ff - 1'b1);
                     count_in  = count_ff - 1'b1;
                     state_in  = S_LOAD;
                  end
               end
            end
         end

         // Parent in rd_data0: move it down while the new key is smaller
         S_UP: begin
            cmp_a = cur_ff.key;
            cmp_b = rd_data0.key;
            if (cmp_lt) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data0;
               pos_in  = parent;
               if (parent == '0) begin
                  wfin_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  rd_addr0 = (parent - 1'b1) >> 1;
               end
            end else begin
               wfin_in  = 1'b1;
               state_in = S_DONE;
            end
         end

         // Root and last entry arrive; start the walk down from the root
         S_LOAD: begin
            okey_in = rd_data0.key;
            otag_in = rd_data0.tag;
            cur_in  = rd_data1;
            pos_in  = '0;
            if (count_ff == '0) begin
               wfin_in  = 1'b0;
               state_in = S_DONE;
            end else if (count_w == IW'(1)) begin
               wfin_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr0 = AW'(1);
               rd_addr1 = AW'(2);
               state_in = S_PICK;
            end
         end

         // Choose the smaller child, left on ties
         S_PICK: begin
            cmp_a = rd_data1.key;
            cmp_b = rd_data0.key;
            if ((rc_w < count_w) && cmp_lt) begin
               pick_in = rd_data1;
               pidx_in = AW'(rc_w);
            end else begin
               pick_in = rd_data0;
               pidx_in = AW'(lc_w);
            end
            state_in = S_SWAP;
         end

         // Lift the child while the moving key is strictly greater
         S_SWAP: begin
            cmp_a = pick_ff.key;
            cmp_b = cur_ff.key;
            if (cmp_lt) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = pick_ff;
               pos_in  = pidx_ff;
               if (nlc_w >= count_w) begin
                  wfin_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  rd_addr0 = AW'(nlc_w);
                  rd_addr1 = AW'(nlc_w + 1'b1);
                  state_in = S_PICK;
               end
            end else begin
               wfin_in  = 1'b1;
               state_in = S_DONE;
            end
         end

         // Drop the moving entry into its hole and hand off the result
         S_DONE: begin
            wr_en   = wfin_ff;
            wr_addr = pos_ff;
            wr_data = cur_ff;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, count and registered result fields
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      pick_ff   <= pick_in;
      pidx_ff   <= pidx_in;
      okey_ff   <= okey_in;
      otag_ff   <= otag_in;
      status_ff <= status_in;
      wfin_ff   <= wfin_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (IW'(wr_addr) < count_w))
      else $error("write outside occupied heap");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status == ST_DROP_FULL)) |-> (count_ff == CW'(DEPTH)))
      else $error("insert dropped while not full");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status == ST_POP_EMPTY)) |-> (count_ff == '0))
      else $error("empty pop reported with entries held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer idle right after accepting a transaction");

endmodule

FILE: dv/binary_min_heap_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_test: self-checking bench for the min-heap queue
// A short table of directed operations is followed by random phases that fill
// the heap past capacity, drain it past empty, and mix both with tight key
// ranges that force ties. Every response is checked field by field against a
// software heap or a row's hand-typed result, under random sender bursts
// and receiver stalls, one long receiver hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top_test;
   import hmq_pkg::*;

   localparam int QUEUE_DEPTH    = 64;
   localparam int RANDOM_ITEMS   = 1900;
   localparam int IDLE_LIMIT     = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DIRECTED_COUNT = 25;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;
   typedef enum int {KEYS_TIGHT, KEYS_WIDE, KEYS_EDGES} key_spread_type;

   // One directed operation; when known is set, rsp is the hand-typed result
   typedef struct packed {
      req_type op;
      logic    known;
      rsp_type rsp;
   } test_row_type;

   localparam test_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b1, '{32'h0, 16'h0, ST_POP_EMPTY, 7'd0}},
      '{'{FUNC_INSERT, 32'h0,         16'h0},    1'b1, '{32'h0, 16'h0, ST_INSERTED, 7'd1}},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b1, '{32'h0, 16'h0, ST_POPPED, 7'd0}},
      '{'{FUNC_POP,    32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{32'h0, 16'h0, ST_POP_EMPTY, 7'd0}},
      '{'{FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{32'h0, 16'h0, ST_INSERTED, 7'd1}},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b1,
        '{32'hFFFF_FFFF, 16'hFFFF, ST_POPPED, 7'd0}},
      '{'{FUNC_INSERT, 32'd5,         16'd1},    1'b1, '{32'h0, 16'h0, ST_INSERTED, 7'd1}},
      '{'{FUNC_INSERT, 32'd5,         16'd2},    1'b1, '{32'h0, 16'h0, ST_INSERTED, 7'd2}},
      '{'{FUNC_INSERT, 32'd5,         16'd3},    1'b1, '{32'h0, 16'h0, ST_INSERTED, 7'd3}},
      '{'{FUNC_INSERT, 32'd3,         16'd4},    1'b0, '0},
      '{'{FUNC_INSERT, 32'd5,         16'd5},    1'b0, '0},
      '{'{FUNC_INSERT, 32'hFFFF_FFFF, 16'd6},    1'b0, '0},
      '{'{FUNC_INSERT, 32'h0,         16'd7},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_INSERT, 32'hAAAA_AAAA, 16'h5555}, 1'b0, '0},
      '{'{FUNC_INSERT, 32'h5555_5555, 16'hAAAA}, 1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b0, '0},
      '{'{FUNC_POP,    32'h0,         16'h0},    1'b1, '{32'h0, 16'h0, ST_POP_EMPTY, 7'd0}}
   };

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Shadow heap and the results it has predicted but not yet seen
   logic [KEY_W-1:0] shadow_keys [QUEUE_DEPTH];
   logic [TAG_W-1:0] shadow_tags [QUEUE_DEPTH];
   int unsigned      shadow_count = 0;
   rsp_type          pending_heap_results [$];

   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned idle_cycles    = 0;
   int          burst_left     = 0;

   binary_min_heap_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #4 clock = ~clock;

   function automatic void swap_shadow(input int unsigned a, input int unsigned b);
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      k = shadow_keys[a];
      t = shadow_tags[a];
      shadow_keys[a] = shadow_keys[b];
      shadow_tags[a] = shadow_tags[b];
      shadow_keys[b] = k;
      shadow_tags[b] = t;
   endfunction

   // Apply one operation to the shadow heap and return the response it yields
   function automatic rsp_type apply_heap_op(input req_type op);
      rsp_type     rsp;
      int unsigned pos, parent, left, right, pick;
      rsp = '0;
      if (op.func == FUNC_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            rsp.status = ST_DROP_FULL;
         end else begin
            shadow_keys[shadow_count] = op.key;
            shadow_tags[shadow_count] = op.tag;
            pos = shadow_count;
            shadow_count++;
            // climb while strictly below the parent
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!(shadow_keys[pos] < shadow_keys[parent])) break;
               swap_shadow(pos, parent);
               pos = parent;
            end
            rsp.status = ST_INSERTED;
         end
      end else begin
         if (shadow_count == 0) begin
            rsp.status = ST_POP_EMPTY;
         end else begin
            rsp.out_key = shadow_keys[0];
            rsp.out_tag = shadow_tags[0];
            shadow_count--;
            if (shadow_count > 0) begin
               shadow_keys[0] = shadow_keys[shadow_count];
               shadow_tags[0] = shadow_tags[shadow_count];
               pos = 0;
               // sink toward the smaller child, left child on ties
               forever begin
                  left  = 2 * pos + 1;
                  right = left + 1;
                  if (left >= shadow_count) break;
                  pick = left;
                  if (right < shadow_count && shadow_keys[right] < shadow_keys[left])
                     pick = right;
                  if (!(shadow_keys[pos] > shadow_keys[pick])) break;
                  swap_shadow(pos, pick);
                  pos = pick;
               end
            end
            rsp.status = ST_POPPED;
         end
      end
      rsp.occupancy = OCC_W'(shadow_count);
      return rsp;
   endfunction

   // Offer one transaction inside the current burst, open a new burst with a
   // random gap when the old one runs out, and record the expected response
   task automatic issue_op(input req_type op, input logic known, input rsp_type known_rsp);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= op;
      do @(posedge clock); while (!req_ready);
      predicted = apply_heap_op(op);
      pending_heap_results.push_back(known ? known_rsp : predicted);
   endtask

   // Stop offering and hold until every expected response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_heap_results.size() != 0) @(posedge clock);
   endtask

   task automatic note_mismatch(input string field, input logic [KEY_W-1:0] want,
                                input logic [KEY_W-1:0] got);
      mismatch_count++;
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
   endtask

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_heap_results.size() == 0) begin
            mismatch_count++;
            $error("response with nothing expected: %h", rsp_payload);
         end else begin
            due = pending_heap_results.pop_front();
            if (rsp_payload.out_key !== due.out_key)
               note_mismatch("out_key", due.out_key, rsp_payload.out_key);
            if (rsp_payload.out_tag !== due.out_tag)
               note_mismatch("out_tag", KEY_W'(due.out_tag), KEY_W'(rsp_payload.out_tag));
            if (rsp_payload.status !== due.status)
               note_mismatch("status", KEY_W'(due.status), KEY_W'(rsp_payload.status));
            if (rsp_payload.occupancy !== due.occupancy)
               note_mismatch("occupancy", KEY_W'(due.occupancy),
                             KEY_W'(rsp_payload.occupancy));
         end
      end
   end

   // End the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver: stall in stretches of varying density, and once hold off long
   // enough for the queue to back up into its input
   initial begin
      int   mode;
      int   span;
      logic long_hold_done;
      long_hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
         if (!long_hold_done && results_seen >= 600) begin
            long_hold_done = 1'b1;
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   // Sender: reset, directed table, then random phases
   initial begin
      req_type        op;
      op_mix_type     mix;
      key_spread_type spread;
      int             issued;
      int             phase;
      int             phase_len;
      int             insert_pct;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         issue_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].rsp);

      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS) begin
         // first phase always overfills the heap
         if (phase == 0) begin
            mix       = MIX_FILL;
            spread    = KEYS_WIDE;
            phase_len = 110;
         end else begin
            mix       = op_mix_type'($urandom_range(0, 2));
            spread    = key_spread_type'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 150);
         end
         case (mix)
            MIX_FILL:  insert_pct = 90;
            MIX_DRAIN: insert_pct = 10;
            default:   insert_pct = 50;
         endcase
         for (int n = 0; n < phase_len && issued < RANDOM_ITEMS; n++) begin
            op.func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_POP;
            case (spread)
               KEYS_TIGHT: op.key = KEY_W'($urandom_range(0, 7));
               KEYS_WIDE:  op.key = KEY_W'($urandom());
               default: begin
                  case ($urandom_range(0, 2))
                     0:       op.key = '0;
                     1:       op.key = '1;
                     default: op.key = KEY_W'($urandom());
                  endcase
               end
            endcase
            op.tag = TAG_W'($urandom());
            issue_op(op, 1'b0, '0);
            issued++;
         end
         // pause once with everything drained
         if (phase == 3) wait_for_drain();
         phase++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_heap_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
